### rtl/lcsmt_pkg.sv
// Shared constants, command/status types and helpers for the Li Chao segment tree.
package lcsmt_pkg;

  localparam int MAX_LEAVES_LOG2 = 10;
  localparam int VALUE_BITS      = 32;

  localparam int LEAF_AW  = MAX_LEAVES_LOG2;
  localparam int NODE_AW  = MAX_LEAVES_LOG2 + 1;
  localparam int CNT_W    = MAX_LEAVES_LOG2 + 1;
  localparam int LR_W     = MAX_LEAVES_LOG2 + 2;
  localparam int LEAF_MAX = 1 << LEAF_AW;
  localparam int NODE_MAX = 1 << NODE_AW;

  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_RANGE = 3'd1;
  localparam logic [2:0] REQ_ALL   = 3'd2;
  localparam logic [2:0] REQ_QUERY = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [3:0] SIZE_LOG2_RST = 4'd10;

  typedef enum logic [1:0] {KEY_LO, KEY_HI, KEY_QX} key_e;
  typedef enum logic [1:0] {CRD_SRCH, CRD_EVAL, CRD_K} crd_src_e;
  typedef enum logic [1:0] {DN_ROOT, DN_L, DN_R} dn_src_e;
  typedef enum logic [1:0] {EV_L, EV_R, EV_M} ev_e;

  typedef struct packed {
    logic     capture;
    logic     coord_wr;
    logic     clr_wr;
    logic     srch_init;
    logic     srch_step;
    key_e     key;
    logic     save_first;
    logic     lr_init;
    logic     l_inc;
    logic     r_dec;
    logic     lr_shift;
    logic     dn_init;
    dn_src_e  dn_src;
    logic     coord_rd;
    crd_src_e crd_src;
    logic     node_rd;
    ev_e      ev;
    logic     mul;
    logic     cmp;
    logic     dn_final;
    logic     dn_next;
    logic     q_init;
    logic     q_acc;
    logic     res_load;
    logic     res_past;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_zero;
    logic range_empty;
    logic lr_done;
    logic l_odd;
    logic r_odd;
    logic dn_stop;
    logic k_past;
    logic qnode_last;
    logic out_free;
  } sts_t;

  // Sign-extend the low VALUE_BITS bits of a field to 32 bits.
  function automatic logic signed [31:0] sext(input logic [31:0] v);
    logic signed [31:0] t;
    t = $signed(v << (32 - VALUE_BITS));
    return t >>> (32 - VALUE_BITS);
  endfunction

endpackage

### rtl/lcsmt_dpath.sv
// Datapath: coordinate and node memories, search, descent, query and result registers.
module lcsmt_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  input  logic [9:0]          coord_index_i,
  input  logic signed [31:0]  coord_value_i,
  input  logic signed [31:0]  slope_i,
  input  logic signed [31:0]  intercept_i,
  input  logic signed [31:0]  seg_lo_i,
  input  logic signed [31:0]  seg_hi_i,
  input  logic signed [31:0]  query_x_i,
  input  logic                out_ready_i,
  input  lcsmt_pkg::cmd_t     cmd_i,
  output lcsmt_pkg::sts_t     sts_o,
  output logic                out_valid_o,
  output logic signed [63:0]  min_value_o,
  output logic                no_line_o,
  output logic                past_end_o
);

  localparam int LEAF_AW = lcsmt_pkg::LEAF_AW;
  localparam int NODE_AW = lcsmt_pkg::NODE_AW;
  localparam int CNT_W   = lcsmt_pkg::CNT_W;
  localparam int LR_W    = lcsmt_pkg::LR_W;
  localparam int UP_W    = $clog2(NODE_AW);

  logic signed [31:0] coord_mem [lcsmt_pkg::LEAF_MAX];
  logic [64:0]        node_mem  [lcsmt_pkg::NODE_MAX];

  logic [3:0]         size_log2_q;
  logic [NODE_AW-1:0] clr_cnt_q;
  logic               out_valid_q;

  logic [LEAF_AW-1:0] coord_index_q;
  logic signed [31:0] coord_value_q, slope_q, intercept_q, seg_lo_q, seg_hi_q, query_x_q;
  logic signed [31:0] coord_rd_q;
  logic [64:0]        node_rd_q;
  logic [CNT_W-1:0]   lo_q, cnt_q, first_q;
  logic [LR_W-1:0]    l_q, r_q;
  logic [NODE_AW-1:0] node_q;
  logic [CNT_W-1:0]   dlo_q, dhi_q;
  logic               lb_q, rb_q, mb_q;
  logic signed [31:0] a_q, b_q;
  logic signed [63:0] prod_a_q, prod_n_q;
  logic signed [63:0] best_q;
  logic               any_q;
  logic signed [63:0] min_value_q;
  logic               no_line_q, past_end_q;

  logic [3:0]         eff;
  logic [CNT_W-1:0]   sz, step, mid;
  logic [LEAF_AW-1:0] srch_addr, ev_addr, crd_addr;
  logic signed [31:0] key;
  logic               go;
  logic [NODE_AW-1:0] dn_node, dn_base;
  logic [UP_W-1:0]    up;
  logic [3:0]         sh;
  logic [CNT_W-1:0]   dn_lo, span;
  logic signed [31:0] ns, nb;
  logic signed [63:0] lhs, rhs, qv;
  logic               below;

  always_comb begin
    eff  = (size_log2_q > 4'(lcsmt_pkg::MAX_LEAVES_LOG2)) ?
           4'(lcsmt_pkg::MAX_LEAVES_LOG2) : size_log2_q;
    sz   = CNT_W'(1) << eff;
    step = cnt_q >> 1;
    srch_addr = LEAF_AW'(lo_q + step);
    mid  = (dlo_q + dhi_q) >> 1;
    case (cmd_i.key)
      lcsmt_pkg::KEY_LO: key = seg_lo_q;
      lcsmt_pkg::KEY_HI: key = seg_hi_q;
      default:           key = query_x_q;
    endcase
    go = (cmd_i.key == lcsmt_pkg::KEY_HI) ? (coord_rd_q <= key) : (coord_rd_q < key);
    case (cmd_i.ev)
      lcsmt_pkg::EV_L: ev_addr = LEAF_AW'(dlo_q);
      lcsmt_pkg::EV_R: ev_addr = LEAF_AW'(dhi_q - CNT_W'(1));
      default:         ev_addr = LEAF_AW'(mid);
    endcase
    case (cmd_i.crd_src)
      lcsmt_pkg::CRD_SRCH: crd_addr = srch_addr;
      lcsmt_pkg::CRD_EVAL: crd_addr = ev_addr;
      default:             crd_addr = LEAF_AW'(lo_q);
    endcase
    case (cmd_i.dn_src)
      lcsmt_pkg::DN_L: dn_node = l_q[NODE_AW-1:0];
      lcsmt_pkg::DN_R: dn_node = r_q[NODE_AW-1:0];
      default:         dn_node = NODE_AW'(1);
    endcase
    up = '0;
    for (int i = 0; i < NODE_AW; i++) begin
      if (dn_node[i]) up = UP_W'(i);
    end
    dn_base = dn_node ^ (NODE_AW'(1) << up);
    sh      = eff - 4'(up);
    dn_lo   = CNT_W'(dn_base << sh);
    span    = sz >> up;
    ns  = $signed(node_rd_q[63:32]);
    nb  = $signed(node_rd_q[31:0]);
    lhs = prod_a_q + 64'(b_q);
    rhs = prod_n_q + 64'(nb);
    qv  = rhs;
    below = !node_rd_q[64] || (lhs < rhs);
  end

  always_comb begin
    sts_o.clr_last    = &clr_cnt_q;
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.range_empty = (lo_q == '0) || (first_q >= lo_q);
    sts_o.lr_done     = (l_q >= r_q);
    sts_o.l_odd       = l_q[0];
    sts_o.r_odd       = r_q[0];
    sts_o.dn_stop     = (lb_q == rb_q) || ((dhi_q - dlo_q) < CNT_W'(2));
    sts_o.k_past      = (lo_q >= sz);
    sts_o.qnode_last  = (node_q == NODE_AW'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= lcsmt_pkg::SIZE_LOG2_RST;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) size_log2_q <= cfg_wdata_i;
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + NODE_AW'(1);
      if (cmd_i.res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.coord_wr) coord_mem[coord_index_q] <= coord_value_q;
    if (cmd_i.coord_rd) coord_rd_q <= coord_mem[crd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      node_mem[clr_cnt_q] <= '0;
    end else if ((cmd_i.dn_final && lb_q) || (cmd_i.dn_next && mb_q)) begin
      node_mem[node_q] <= {1'b1, a_q, b_q};
    end
    if (cmd_i.node_rd) node_rd_q <= node_mem[node_q];
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      coord_index_q <= coord_index_i[LEAF_AW-1:0];
      coord_value_q <= lcsmt_pkg::sext(coord_value_i);
      slope_q       <= lcsmt_pkg::sext(slope_i);
      intercept_q   <= lcsmt_pkg::sext(intercept_i);
      seg_lo_q      <= lcsmt_pkg::sext(seg_lo_i);
      seg_hi_q      <= lcsmt_pkg::sext(seg_hi_i);
      query_x_q     <= lcsmt_pkg::sext(query_x_i);
    end
    if (cmd_i.srch_init) begin
      lo_q  <= '0;
      cnt_q <= sz;
    end else if (cmd_i.srch_step) begin
      if (go) begin
        lo_q  <= lo_q + step + CNT_W'(1);
        cnt_q <= cnt_q - step - CNT_W'(1);
      end else begin
        cnt_q <= step;
      end
    end
    if (cmd_i.save_first) first_q <= lo_q;
    if (cmd_i.lr_init) begin
      l_q <= LR_W'(first_q) + LR_W'(sz);
      r_q <= LR_W'(lo_q) + LR_W'(sz);
    end else begin
      if (cmd_i.l_inc)    l_q <= l_q + LR_W'(1);
      if (cmd_i.r_dec)    r_q <= r_q - LR_W'(1);
      if (cmd_i.lr_shift) begin
        l_q <= l_q >> 1;
        r_q <= r_q >> 1;
      end
    end
    if (cmd_i.mul) begin
      prod_a_q <= a_q * coord_rd_q;
      prod_n_q <= ns * coord_rd_q;
    end
    if (cmd_i.cmp) begin
      case (cmd_i.ev)
        lcsmt_pkg::EV_L: lb_q <= below;
        lcsmt_pkg::EV_R: rb_q <= below;
        default:         mb_q <= below;
      endcase
    end
    if (cmd_i.dn_init) begin
      node_q <= dn_node;
      dlo_q  <= dn_lo;
      dhi_q  <= dn_lo + span;
      a_q    <= slope_q;
      b_q    <= intercept_q;
    end else if (cmd_i.dn_final) begin
      if (lb_q && node_rd_q[64]) begin
        a_q <= ns;
        b_q <= nb;
      end
    end else if (cmd_i.dn_next) begin
      if (mb_q && node_rd_q[64]) begin
        a_q <= ns;
        b_q <= nb;
      end
      if (lb_q != mb_q) begin
        node_q <= {node_q[NODE_AW-2:0], 1'b0};
        dhi_q  <= mid;
      end else begin
        node_q <= {node_q[NODE_AW-2:0], 1'b1};
        dlo_q  <= mid;
      end
    end else if (cmd_i.q_init) begin
      node_q <= NODE_AW'(lo_q) + NODE_AW'(sz);
      best_q <= '0;
      any_q  <= 1'b0;
    end else if (cmd_i.q_acc) begin
      if (node_rd_q[64]) begin
        if (!any_q || (qv < best_q)) best_q <= qv;
        any_q <= 1'b1;
      end
      node_q <= node_q >> 1;
    end
    if (cmd_i.res_load) begin
      min_value_q <= (cmd_i.res_past || !any_q) ? 64'sd0 : best_q;
      no_line_q   <= cmd_i.res_past || !any_q;
      past_end_q  <= cmd_i.res_past;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_value_o = min_value_q;
  assign no_line_o   = no_line_q;
  assign past_end_o  = past_end_q;

endmodule

### rtl/lcsmt_ctrl.sv
// Controller: sequences searches, range splitting, node descents, queries and clears.
module lcsmt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2:0]      req_type_i,
  input  lcsmt_pkg::sts_t sts_i,
  output lcsmt_pkg::cmd_t cmd_o,
  output logic            in_ready_o
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD, S_SINIT, S_SA, S_SC, S_SDONE, S_RCHK, S_RR,
    S_DINIT, S_EA, S_EM, S_EC, S_DDEC, S_DNXT, S_QRD, S_QM, S_QA, S_QOUT, S_QPAST
  } state_e;

  state_e              state_q;
  lcsmt_pkg::key_e     ph_q;
  lcsmt_pkg::dn_src_e  ret_q;
  lcsmt_pkg::ev_e      ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ph_q    <= lcsmt_pkg::KEY_LO;
      ret_q   <= lcsmt_pkg::DN_ROOT;
      ev_q    <= lcsmt_pkg::EV_L;
    end else begin
      case (state_q)
        S_CLR: if (sts_i.clr_last) state_q <= S_IDLE;
        S_IDLE: begin
          if (in_valid_i) begin
            case (req_type_i)
              lcsmt_pkg::REQ_LOAD: state_q <= S_LOAD;
              lcsmt_pkg::REQ_RANGE: begin
                ph_q    <= lcsmt_pkg::KEY_LO;
                state_q <= S_SINIT;
              end
              lcsmt_pkg::REQ_ALL: begin
                ret_q   <= lcsmt_pkg::DN_ROOT;
                state_q <= S_DINIT;
              end
              lcsmt_pkg::REQ_QUERY: begin
                ph_q    <= lcsmt_pkg::KEY_QX;
                state_q <= S_SINIT;
              end
              lcsmt_pkg::REQ_CLEAR: state_q <= S_CLR;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_LOAD:  state_q <= S_IDLE;
        S_SINIT: state_q <= S_SA;
        S_SA:    state_q <= sts_i.cnt_zero ? S_SDONE : S_SC;
        S_SC:    state_q <= S_SA;
        S_SDONE: begin
          case (ph_q)
            lcsmt_pkg::KEY_LO: begin
              ph_q    <= lcsmt_pkg::KEY_HI;
              state_q <= S_SINIT;
            end
            lcsmt_pkg::KEY_HI: state_q <= sts_i.range_empty ? S_IDLE : S_RCHK;
            default:           state_q <= sts_i.k_past ? S_QPAST : S_QRD;
          endcase
        end
        S_RCHK: begin
          if (sts_i.lr_done) begin
            state_q <= S_IDLE;
          end else if (sts_i.l_odd) begin
            ret_q   <= lcsmt_pkg::DN_L;
            state_q <= S_DINIT;
          end else begin
            state_q <= S_RR;
          end
        end
        S_RR: begin
          if (sts_i.r_odd) begin
            ret_q   <= lcsmt_pkg::DN_R;
            state_q <= S_DINIT;
          end else begin
            state_q <= S_RCHK;
          end
        end
        S_DINIT: begin
          ev_q    <= lcsmt_pkg::EV_L;
          state_q <= S_EA;
        end
        S_EA: state_q <= S_EM;
        S_EM: state_q <= S_EC;
        S_EC: begin
          case (ev_q)
            lcsmt_pkg::EV_L: begin
              ev_q    <= lcsmt_pkg::EV_R;
              state_q <= S_EA;
            end
            lcsmt_pkg::EV_R: state_q <= S_DDEC;
            default:         state_q <= S_DNXT;
          endcase
        end
        S_DDEC: begin
          if (sts_i.dn_stop) begin
            case (ret_q)
              lcsmt_pkg::DN_L: state_q <= S_RR;
              lcsmt_pkg::DN_R: state_q <= S_RCHK;
              default:         state_q <= S_IDLE;
            endcase
          end else begin
            ev_q    <= lcsmt_pkg::EV_M;
            state_q <= S_EA;
          end
        end
        S_DNXT: begin
          ev_q    <= lcsmt_pkg::EV_L;
          state_q <= S_EA;
        end
        S_QRD: state_q <= S_QM;
        S_QM:  state_q <= S_QA;
        S_QA:  state_q <= sts_i.qnode_last ? S_QOUT : S_QRD;
        S_QOUT:  if (sts_i.out_free) state_q <= S_IDLE;
        S_QPAST: if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.key     = ph_q;
    cmd_o.dn_src  = ret_q;
    cmd_o.ev      = ev_q;
    cmd_o.crd_src = lcsmt_pkg::CRD_SRCH;
    in_ready_o    = 1'b0;
    case (state_q)
      S_CLR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_LOAD:  cmd_o.coord_wr  = 1'b1;
      S_SINIT: cmd_o.srch_init = 1'b1;
      S_SA:    cmd_o.coord_rd  = !sts_i.cnt_zero;
      S_SC:    cmd_o.srch_step = 1'b1;
      S_SDONE: begin
        case (ph_q)
          lcsmt_pkg::KEY_LO: cmd_o.save_first = 1'b1;
          lcsmt_pkg::KEY_HI: cmd_o.lr_init    = !sts_i.range_empty;
          default: begin
            cmd_o.coord_rd = !sts_i.k_past;
            cmd_o.crd_src  = lcsmt_pkg::CRD_K;
            cmd_o.q_init   = !sts_i.k_past;
          end
        endcase
      end
      S_RR: begin
        cmd_o.r_dec    = sts_i.r_odd;
        cmd_o.lr_shift = !sts_i.r_odd;
      end
      S_DINIT: cmd_o.dn_init = 1'b1;
      S_EA: begin
        cmd_o.coord_rd = 1'b1;
        cmd_o.crd_src  = lcsmt_pkg::CRD_EVAL;
        cmd_o.node_rd  = 1'b1;
      end
      S_EM: cmd_o.mul = 1'b1;
      S_EC: cmd_o.cmp = 1'b1;
      S_DDEC: begin
        cmd_o.dn_final = sts_i.dn_stop;
        cmd_o.l_inc    = sts_i.dn_stop && (ret_q == lcsmt_pkg::DN_L);
        cmd_o.lr_shift = sts_i.dn_stop && (ret_q == lcsmt_pkg::DN_R);
      end
      S_DNXT: cmd_o.dn_next = 1'b1;
      S_QRD:  cmd_o.node_rd = 1'b1;
      S_QM:   cmd_o.mul     = 1'b1;
      S_QA:   cmd_o.q_acc   = 1'b1;
      S_QOUT: cmd_o.res_load = sts_i.out_free;
      S_QPAST: begin
        cmd_o.res_load = sts_i.out_free;
        cmd_o.res_past = 1'b1;
      end
      default: cmd_o = cmd_o;
    endcase
  end

endmodule

### rtl/li_chao_segment_min_tree.sv
// Top level of the Li Chao segment tree: lower envelope of lines over loaded coordinates.
//
//   channel   direction  handshake                 word
//   cfg       in         cfg_we_i                  cfg_wdata_i (size_log2)
//   in        in         in_valid_i / in_ready_o   req_type_i .. query_x_i
//   out       out        out_valid_o / out_ready_i min_value_o, no_line_o, past_end_o
//
// One word is worked at a time; in_ready_o is high only while the controller idles.
// A ranged insert runs the two searches, then walks the split levels with a descent per
// canonical node. Multiply-compare steps are serial, on one registered read port of each
// memory.
// After reset a pass clears the node valid bits before any word is taken;
// configuration writes are taken throughout.
// A query result waits in the output register; the next word is accepted meanwhile and
// a further query holds only if its result is ready before the old one is taken.
module li_chao_segment_min_tree (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic [9:0]         coord_index_i,
  input  logic signed [31:0] coord_value_i,
  input  logic signed [31:0] slope_i,
  input  logic signed [31:0] intercept_i,
  input  logic signed [31:0] seg_lo_i,
  input  logic signed [31:0] seg_hi_i,
  input  logic signed [31:0] query_x_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] min_value_o,
  output logic               no_line_o,
  output logic               past_end_o
);

  lcsmt_pkg::cmd_t cmd;
  lcsmt_pkg::sts_t sts;

  // Sequence each request kind.
  lcsmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  // Hold memories, search and descent registers, and the result word.
  lcsmt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .coord_index_i (coord_index_i),
    .coord_value_i (coord_value_i),
    .slope_i       (slope_i),
    .intercept_i   (intercept_i),
    .seg_lo_i      (seg_lo_i),
    .seg_hi_i      (seg_hi_i),
    .query_x_i     (query_x_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .min_value_o   (min_value_o),
    .no_line_o     (no_line_o),
    .past_end_o    (past_end_o)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for li_chao_segment_min_tree with its own envelope predictor.
module testbench;

  // Request codes the block ignores; use them to check that no result appears.
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 600;
  localparam int PHASES = 6;
  // Leaves loaded up front; every size used stays within them.
  localparam int TABLE_LOG2 = 7;
  localparam int TABLE_LEAVES = 1 << TABLE_LOG2;
  // Cover the slowest word (a clear or a full ranged insert) before a register write.
  localparam int SETTLE_CYCLES = 4000;

  typedef struct {
    longint mval;
    bit     nl;
    bit     pe;
  } minimum_t;

  typedef struct {
    logic [2:0]         req;
    logic [9:0]         idx;
    logic signed [31:0] cval;
    logic signed [31:0] slope;
    logic signed [31:0] icpt;
    logic signed [31:0] slo;
    logic signed [31:0] shi;
    logic signed [31:0] qx;
    bit                 typed;
    minimum_t           fixed;
  } word_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [3:0] cfg_wdata;
  logic in_valid, in_ready_o;
  logic [2:0] req_type;
  logic [9:0] coord_index;
  logic signed [31:0] coord_value, slope, intercept, seg_lo, seg_hi, query_x;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic signed [63:0] min_value_o;
  logic no_line_o, past_end_o;

  // Envelope mirror: coordinates, node lines and the size register.
  longint crd[lcsmt_pkg::LEAF_MAX];
  longint nslope[lcsmt_pkg::NODE_MAX];
  longint nicpt[lcsmt_pkg::NODE_MAX];
  bit     nvalid[lcsmt_pkg::NODE_MAX];
  logic [3:0] size_reg;

  minimum_t pending_minima[$];
  word_t    directed_rows[$];
  int errors = 0;
  int stall = 0;
  bit quiet;

  li_chao_segment_min_tree u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o),
    .req_type_i(req_type), .coord_index_i(coord_index), .coord_value_i(coord_value),
    .slope_i(slope), .intercept_i(intercept), .seg_lo_i(seg_lo), .seg_hi_i(seg_hi),
    .query_x_i(query_x),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready),
    .min_value_o(min_value_o), .no_line_o(no_line_o), .past_end_o(past_end_o)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned leaf_count();
    return 1 << ((size_reg > 4'(lcsmt_pkg::MAX_LEAVES_LOG2)) ?
                 lcsmt_pkg::MAX_LEAVES_LOG2 : int'(size_reg));
  endfunction

  // Binary search: first leaf with coordinate >= key, or > key when strict.
  function automatic int unsigned find_leaf(int unsigned n, longint key, bit strict);
    int unsigned lo, cnt, step;
    longint c;
    lo = 0;
    cnt = n;
    while (cnt > 0) begin
      step = cnt / 2;
      c = crd[(lo + step) % lcsmt_pkg::LEAF_MAX];
      if (strict ? (c <= key) : (c < key)) begin
        lo += step + 1;
        cnt -= step + 1;
      end else begin
        cnt = step;
      end
    end
    return lo;
  endfunction

  function automatic bit lies_below(longint a, longint b, int unsigned node, longint x);
    if (!nvalid[node]) return 1'b1;
    return (a * x + b) < (nslope[node] * x + nicpt[node]);
  endfunction

  // Keep the lower line in the node, push the other one toward where it still wins.
  function automatic void keep_lower(longint a, longint b, int unsigned node);
    int unsigned sz, up, lo, hi, mid;
    bit lb, rb, mb;
    longint ta, tb;
    bit had;
    sz = leaf_count();
    up = 0;
    while ((node >> (up + 1)) != 0) up++;
    lo = (sz >> up) * (node - (1 << up));
    hi = lo + (sz >> up);
    forever begin
      mid = (lo + hi) >> 1;
      lb = lies_below(a, b, node, crd[lo % lcsmt_pkg::LEAF_MAX]);
      rb = lies_below(a, b, node, crd[(hi - 1) % lcsmt_pkg::LEAF_MAX]);
      if (lb == rb || hi - lo < 2) begin
        if (lb) begin
          nslope[node] = a;
          nicpt[node] = b;
          nvalid[node] = 1'b1;
        end
        return;
      end
      mb = lies_below(a, b, node, crd[mid % lcsmt_pkg::LEAF_MAX]);
      if (mb) begin
        ta = nslope[node];
        tb = nicpt[node];
        had = nvalid[node];
        nslope[node] = a;
        nicpt[node] = b;
        nvalid[node] = 1'b1;
        if (had) begin
          a = ta;
          b = tb;
        end
      end
      if (lb != mb) begin
        node = node << 1;
        hi = mid;
      end else begin
        node = (node << 1) | 1;
        lo = mid;
      end
    end
  endfunction

  function automatic void insert_segment(longint a, longint b, longint xlo, longint xhi);
    int unsigned sz, first, past, l, r;
    sz = leaf_count();
    first = find_leaf(sz, xlo, 1'b0);
    past = find_leaf(sz, xhi, 1'b1);
    if (past == 0 || first >= past) return;
    l = first + sz;
    r = past + sz;
    while (l < r) begin
      if (l & 1) begin
        keep_lower(a, b, l);
        l++;
      end
      if (r & 1) begin
        r--;
        keep_lower(a, b, r);
      end
      l >>= 1;
      r >>= 1;
    end
  endfunction

  function automatic minimum_t path_minimum(longint qx);
    minimum_t m;
    int unsigned sz, k, node;
    longint x, v;
    sz = leaf_count();
    k = find_leaf(sz, qx, 1'b0);
    m = '{0, 1'b1, 1'b0};
    if (k >= sz) begin
      m.pe = 1'b1;
      return m;
    end
    x = crd[k % lcsmt_pkg::LEAF_MAX];
    for (node = k + sz; node >= 1; node >>= 1) begin
      if (nvalid[node]) begin
        v = nslope[node] * x + nicpt[node];
        if (m.nl || v < m.mval) m.mval = v;
        m.nl = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic void apply_word(word_t w);
    minimum_t m;
    case (w.req)
      lcsmt_pkg::REQ_LOAD:  crd[w.idx] = w.cval;
      lcsmt_pkg::REQ_RANGE: insert_segment(w.slope, w.icpt, w.slo, w.shi);
      lcsmt_pkg::REQ_ALL:   keep_lower(w.slope, w.icpt, 1);
      lcsmt_pkg::REQ_QUERY: begin
        m = path_minimum(w.qx);
        pending_minima = {pending_minima, (w.typed ? w.fixed : m)};
      end
      lcsmt_pkg::REQ_CLEAR: for (int i = 0; i < lcsmt_pkg::NODE_MAX; i++) nvalid[i] = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t blank_word(logic [2:0] req);
    word_t w;
    w.req = req;
    w.idx = 10'($urandom);
    w.cval = $urandom;
    w.slope = $urandom;
    w.icpt = $urandom;
    w.slo = $urandom;
    w.shi = $urandom;
    w.qx = $urandom;
    w.typed = 1'b0;
    w.fixed = '{0, 1'b1, 1'b0};
    return w;
  endfunction

  // Pick an x near a loaded coordinate in use, or anywhere at all.
  function automatic logic signed [31:0] pick_x();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'(crd[$urandom_range(0, leaf_count() - 1)] + $urandom_range(0, 4) - 2);
  endfunction

  function automatic word_t random_word();
    word_t w;
    logic signed [31:0] t;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      w = blank_word(lcsmt_pkg::REQ_QUERY);
    else if (r < 66) w = blank_word(lcsmt_pkg::REQ_RANGE);
    else if (r < 81) w = blank_word(lcsmt_pkg::REQ_ALL);
    else if (r < 91) w = blank_word(lcsmt_pkg::REQ_LOAD);
    else if (r < 94) w = blank_word(lcsmt_pkg::REQ_CLEAR);
    else             w = blank_word(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)));
    if ($urandom_range(0, 1)) w.slope = $urandom_range(0, 200) - 100;
    if ($urandom_range(0, 1)) w.icpt = $urandom_range(0, 2000000) - 1000000;
    case (w.req)
      lcsmt_pkg::REQ_QUERY: w.qx = pick_x();
      lcsmt_pkg::REQ_RANGE: begin
        w.slo = pick_x();
        w.shi = pick_x();
        // Keep most ranges well formed; leave the rest reversed.
        if (w.slo > w.shi && $urandom_range(0, 4) != 0) begin
          t = w.slo;
          w.slo = w.shi;
          w.shi = t;
        end
      end
      lcsmt_pkg::REQ_LOAD: if ($urandom_range(0, 9) < 7) w.cval = 32'(crd[w.idx]);
      default: ;
    endcase
    return w;
  endfunction

  // Present one word, hold it until taken, then idle for a random gap.
  task automatic send_word(word_t w);
    int gap;
    in_valid <= 1'b1;
    req_type <= w.req;
    coord_index <= w.idx;
    coord_value <= w.cval;
    slope <= w.slope;
    intercept <= w.icpt;
    seg_lo <= w.slo;
    seg_hi <= w.shi;
    query_x <= w.qx;
    do @(posedge clk); while (!in_ready_o);
    apply_word(w);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected minimum has drained.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_minima.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = v;
  endtask

  task automatic add_row(logic [2:0] req, logic signed [31:0] a, logic signed [31:0] b,
                         logic signed [31:0] lo, logic signed [31:0] hi,
                         bit typed, minimum_t fixed);
    word_t w;
    w = blank_word(req);
    w.slope = a;
    w.icpt = b;
    w.slo = lo;
    w.shi = hi;
    w.qx = lo;
    w.typed = typed;
    w.fixed = fixed;
    directed_rows = {directed_rows, w};
  endtask

  // Drive the result side: random stalls, none while quiet.
  always @(posedge clk) begin
    if (stall > 0) begin
      out_ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25)
        stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
  end

  // Compare each taken result against the oldest expected minimum.
  always @(posedge clk) begin
    minimum_t m;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_minima.size() == 0) begin
        $error("result with nothing expected: min_value %0d", min_value_o);
        errors++;
      end else begin
        m = pending_minima.pop_front();
        if (min_value_o !== m.mval) begin
          $error("min_value expected %0d actual %0d", m.mval, min_value_o);
          errors++;
        end
        if (no_line_o !== m.nl) begin
          $error("no_line expected %0d actual %0d", m.nl, no_line_o);
          errors++;
        end
        if (past_end_o !== m.pe) begin
          $error("past_end expected %0d actual %0d", m.pe, past_end_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("li_chao_segment_min_tree regression: fail");
    $finish;
  end

  initial begin
    word_t w;
    minimum_t none, past, dummy;
    longint c;
    logic [3:0] sizes[PHASES];
    quiet = 1'b0;
    size_reg = lcsmt_pkg::SIZE_LOG2_RST;
    none = '{0, 1'b1, 1'b0};
    past = '{0, 1'b1, 1'b1};
    dummy = none;
    sizes = '{4'(TABLE_LOG2), 4'd0, 4'd3, 4'd1, 4'd6, 4'd5};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    req_type = '0;
    coord_index = '0;
    coord_value = '0;
    slope = '0;
    intercept = '0;
    seg_lo = '0;
    seg_hi = '0;
    query_x = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Shrink to the table size before any word is sent.
    write_size(sizes[0]);

    // Load a sorted table from the most negative value upward, with a few repeats;
    // the top stays well below the maximum so a query can run past the end.
    c = -64'sd2147483648;
    for (int i = 0; i < TABLE_LEAVES; i++) begin
      w = blank_word(lcsmt_pkg::REQ_LOAD);
      w.idx = 10'(i);
      w.cval = 32'(c);
      send_word(w);
      if ($urandom_range(0, 19) != 0) c += $urandom_range(1, 2000000);
    end

    // Directed rows: empty tree, past end, extremes, empty and single-point ranges.
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'sh80000000, 0, 1'b1, none);
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'sh7fffffff, 0, 1'b1, past);
    add_row(lcsmt_pkg::REQ_ALL, 0, 0, 0, 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'(crd[60]), 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'(crd[60]), 0, 1'b1, none);
    add_row(lcsmt_pkg::REQ_ALL, 32'sh7fffffff, 32'sh80000000, 0, 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_ALL, 32'sh80000000, 32'sh7fffffff, 0, 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'sh80000000, 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'(crd[63] - 1), 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'(crd[TABLE_LEAVES - 1]), 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_RANGE, -1, 5, 32'sh80000000, 32'sh7fffffff, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_RANGE, 3, -7, 32'(crd[100]), 32'(crd[20]), 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_RANGE, -9, 11, 32'(crd[20]), 32'(crd[20]), 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_RANGE, 1, 0, 32'(crd[40] + 1), 32'(crd[41] - 1), 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'(crd[20]), 0, 1'b0, dummy);
    add_row(lcsmt_pkg::REQ_QUERY, 0, 0, 32'(crd[21]), 0, 1'b0, dummy);
    add_row(REQ_SPARE_LO, 0, 0, 0, 0, 1'b0, dummy);
    add_row(REQ_SPARE_HI, 0, 0, 0, 0, 1'b0, dummy);
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    // Largest coordinate at the top leaf, then restore the table.
    w = blank_word(lcsmt_pkg::REQ_LOAD);
    w.idx = 10'(TABLE_LEAVES - 1);
    c = crd[TABLE_LEAVES - 1];
    w.cval = 32'sh7fffffff;
    send_word(w);
    w = blank_word(lcsmt_pkg::REQ_QUERY);
    w.qx = 32'sh7fffffff;
    send_word(w);
    w = blank_word(lcsmt_pkg::REQ_LOAD);
    w.idx = 10'(TABLE_LEAVES - 1);
    w.cval = 32'(c);
    send_word(w);

    // Random phases, one per size setting; the table size runs first.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) write_size(sizes[p]);
      quiet = (p == 2);
      for (int i = 0; i < RANDOM_WORDS / PHASES; i++) begin
        // Hold off once mid-phase until every expected minimum is in.
        if (p == 3 && i == 50) drain();
        send_word(random_word());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("li_chao_segment_min_tree regression: pass");
    else $display("li_chao_segment_min_tree regression: fail");
    $finish;
  end
endmodule

### li_chao_segment_min_tree.f
rtl/lcsmt_pkg.sv
rtl/lcsmt_dpath.sv
rtl/lcsmt_ctrl.sv
rtl/li_chao_segment_min_tree.sv
dv/testbench.sv
